/* src/md5_pkg.sv */
`timescale 1ns / 1ps
package md5_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       is_last;
  } md5_in_t;

  typedef struct packed {
    logic [63:0] digest_head;
    logic [63:0] digest_tail;
  } md5_out_t;

  localparam logic [31:0] IvA = 32'h67452301;
  localparam logic [31:0] IvB = 32'hefcdab89;
  localparam logic [31:0] IvC = 32'h98badcfe;
  localparam logic [31:0] IvD = 32'h10325476;

  localparam logic [31:0] RoundK [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Message word index used by round r.
  function automatic logic [3:0] msg_index(input logic [5:0] r);
    logic [3:0] lo;
    lo = r[3:0];
    unique case (r[5:4])
      2'd0: msg_index = lo;
      2'd1: msg_index = 4'((lo * 5) + 1);
      2'd2: msg_index = 4'((lo * 3) + 5);
      default: msg_index = 4'(lo * 7);
    endcase
  endfunction

  function automatic logic [4:0] rot_amt(input logic [5:0] r);
    logic [4:0] s;
    unique case ({r[5:4], r[1:0]})
      4'h0: s = 5'd7;  4'h1: s = 5'd12; 4'h2: s = 5'd17; 4'h3: s = 5'd22;
      4'h4: s = 5'd5;  4'h5: s = 5'd9;  4'h6: s = 5'd14; 4'h7: s = 5'd20;
      4'h8: s = 5'd4;  4'h9: s = 5'd11; 4'ha: s = 5'd16; 4'hb: s = 5'd23;
      4'hc: s = 5'd6;  4'hd: s = 5'd10; 4'he: s = 5'd15; default: s = 5'd21;
    endcase
    rot_amt = s;
  endfunction

  function automatic logic [31:0] bswap(input logic [31:0] v);
    bswap = {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

/* src/md5_round.sv */
`timescale 1ns / 1ps
module md5_round (
  input  logic [5:0]  round_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic [31:0] c_i,
  input  logic [31:0] d_i,
  input  logic [31:0] m_i,
  output logic [31:0] b_o
);
  import md5_pkg::*;

  logic [31:0] f;
  logic [31:0] sum;
  logic [4:0]  s;
  logic [63:0] dbl;

  always_comb begin
    unique case (round_i[5:4])
      2'd0: f = (b_i & c_i) | (~b_i & d_i);
      2'd1: f = (b_i & d_i) | (c_i & ~d_i);
      2'd2: f = b_i ^ c_i ^ d_i;
      default: f = c_i ^ (b_i | ~d_i);
    endcase
    sum = a_i + f + RoundK[round_i] + m_i;
    s   = rot_amt(round_i);
    dbl = {sum, sum} << s;
    b_o = b_i + dbl[63:32];
  end
endmodule

/* src/md5_hash_engine.sv */
`timescale 1ns / 1ps
// Streaming MD5: at most one message byte per transaction, digest on the last one.
// For a data byte, the accept cycle reads its block-store word, the next merges it.
// A full block adds 64 compression rounds plus one fold step; no new byte is accepted
// until the fold is done. After a finish is accepted, the engine pads, compresses and
// presents the digest.
// Reset (rst_ni low, asynchronous) loads the initial chaining value and a zero count.
module md5_hash_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  md5_pkg::md5_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output md5_pkg::md5_out_t out_data_o
);
  import md5_pkg::*;

  // Sequencer states.
  localparam logic [2:0] StIdle  = 3'd0; // waiting for a transaction
  localparam logic [2:0] StMerge = 3'd1; // block word read is back, merge byte
  localparam logic [2:0] StComp  = 3'd2; // one compression round per cycle
  localparam logic [2:0] StFold  = 3'd3; // add working vars into chaining value
  localparam logic [2:0] StPad   = 3'd4; // write padding words one per cycle
  localparam logic [2:0] StOut   = 3'd5; // digest waiting to be taken

  logic [2:0]  state_q, state_d;

  // Block store: 16 words, one write and one registered read port.
  logic [31:0] mem [16];
  logic        mem_we;
  logic [3:0]  mem_waddr, mem_raddr;
  logic [31:0] mem_wdata, mem_rdata_q;
  logic        fwd_q;
  logic [31:0] fwd_data_q;
  logic [31:0] mem_rdata;

  // A read of the word written at the same edge returns the new data through the bypass.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= mem[mem_raddr];
    fwd_q       <= mem_we && (mem_waddr == mem_raddr);
    fwd_data_q  <= mem_wdata;
  end

  assign mem_rdata = fwd_q ? fwd_data_q : mem_rdata_q;

  logic [31:0] cv_q [4];
  logic [31:0] cv_d [4];
  logic [31:0] a_q, b_q, c_q, d_q, a_d, b_d, c_d, d_d;
  logic [63:0] cnt_q, cnt_d;
  logic [6:0]  rnd_q, rnd_d;     // compression round, bit 6 unused beyond 64
  logic [3:0]  pidx_q, pidx_d;   // padding word index
  logic        fin_q, fin_d;     // finishing the message
  logic        two_q, two_d;     // padding needs an extra block
  md5_in_t     item_q, item_d;
  md5_out_t    dig_q, dig_d;
  logic [31:0] rb;

  logic [5:0] pos;
  assign pos = cnt_q[8:3];

  md5_round u_round (
    .round_i(rnd_q[5:0]), .a_i(a_q), .b_i(b_q), .c_i(c_q), .d_i(d_q),
    .m_i(mem_rdata), .b_o(rb)
  );

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);
  assign out_data_o  = dig_q;

  always_comb begin
    logic [31:0] merged;
    logic [5:0]  nr;
    state_d = state_q; cv_d = cv_q;
    a_d = a_q; b_d = b_q; c_d = c_q; d_d = d_q;
    cnt_d = cnt_q; rnd_d = rnd_q; pidx_d = pidx_q;
    fin_d = fin_q; two_d = two_q; item_d = item_q; dig_d = dig_q;
    mem_we = 1'b0; mem_waddr = pos[5:2]; mem_wdata = '0;
    mem_raddr = pos[5:2];
    merged = '0;
    nr = rnd_q[5:0] + 6'd1;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          item_d = in_data_i;
          if (in_data_i.has_byte) begin
            state_d = StMerge;
          end else if (in_data_i.is_last) begin
            fin_d = 1'b1;
            state_d = StMerge;
          end
        end
      end
      StMerge: begin
        // Store the data byte, or the 0x80 marker when finishing.
        unique case (pos[1:0])
          2'd0: merged = 32'h0;
          2'd1: merged = {24'h0, mem_rdata[7:0]};
          2'd2: merged = {16'h0, mem_rdata[15:0]};
          default: merged = {8'h0, mem_rdata[23:0]};
        endcase
        mem_we = 1'b1;
        mem_wdata = merged | (32'((fin_q ? 8'h80 : item_q.data_byte)) << {pos[1:0], 3'b0});
        if (fin_q) begin
          two_d  = (pos >= 6'd56);
          pidx_d = pos[5:2] + 4'd1;
          state_d = StPad;
          if (pos[5:2] == 4'd15) begin
            state_d = StComp; rnd_d = '0; mem_raddr = msg_index(6'd0);
            a_d = cv_q[0]; b_d = cv_q[1]; c_d = cv_q[2]; d_d = cv_q[3];
          end
        end else begin
          cnt_d = cnt_q + 64'd8;
          if (pos == 6'd63) begin
            state_d = StComp; rnd_d = '0; mem_raddr = msg_index(6'd0);
            a_d = cv_q[0]; b_d = cv_q[1]; c_d = cv_q[2]; d_d = cv_q[3];
          end else if (item_q.is_last) begin
            fin_d = 1'b1; state_d = StMerge; mem_raddr = cnt_d[8:5];
          end else begin
            state_d = StIdle;
          end
        end
      end
      StPad: begin
        // Zero words; the last two get the bit count unless a second block follows.
        mem_we = 1'b1; mem_waddr = pidx_q;
        if (!two_q && pidx_q == 4'd14) begin
          mem_wdata = cnt_q[31:0];
        end else if (!two_q && pidx_q == 4'd15) begin
          mem_wdata = cnt_q[63:32];
        end
        pidx_d = pidx_q + 4'd1;
        if (pidx_q == 4'd15) begin
          state_d = StComp; rnd_d = '0;
          a_d = cv_q[0]; b_d = cv_q[1]; c_d = cv_q[2]; d_d = cv_q[3];
        end
        mem_raddr = msg_index(6'd0);
      end
      StComp: begin
        a_d = d_q; d_d = c_q; c_d = b_q; b_d = rb;
        mem_raddr = msg_index(nr);
        rnd_d = rnd_q + 7'd1;
        if (rnd_q[5:0] == 6'd63) begin
          state_d = StFold;
        end
      end
      default: begin
        if (state_q == StFold) begin
          cv_d[0] = cv_q[0] + a_q; cv_d[1] = cv_q[1] + b_q;
          cv_d[2] = cv_q[2] + c_q; cv_d[3] = cv_q[3] + d_q;
          if (!fin_q) begin
            if (item_q.is_last) begin
              fin_d = 1'b1; state_d = StMerge; mem_raddr = cnt_q[8:5];
            end else begin
              state_d = StIdle;
            end
          end else if (two_q) begin
            two_d = 1'b0; pidx_d = '0; state_d = StPad;
          end else begin
            dig_d.digest_head = {bswap(cv_d[0]), bswap(cv_d[1])};
            dig_d.digest_tail = {bswap(cv_d[2]), bswap(cv_d[3])};
            state_d = StOut;
          end
        end else if (state_q == StOut) begin
          if (out_ready_i) begin
            cv_d[0] = IvA; cv_d[1] = IvB; cv_d[2] = IvC; cv_d[3] = IvD;
            cnt_d = '0; fin_d = 1'b0; two_d = 1'b0; state_d = StIdle;
          end
        end else begin
          state_d = StIdle;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cv_q[0] <= IvA; cv_q[1] <= IvB; cv_q[2] <= IvC; cv_q[3] <= IvD;
      cnt_q <= '0; rnd_q <= '0; pidx_q <= '0; fin_q <= 1'b0; two_q <= 1'b0;
    end else begin
      state_q <= state_d; cv_q <= cv_d; cnt_q <= cnt_d;
      rnd_q <= rnd_d; pidx_q <= pidx_d; fin_q <= fin_d; two_q <= two_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d; b_q <= b_d; c_q <= c_d; d_q <= d_d;
    item_q <= item_d; dig_q <= dig_d;
  end
endmodule
